>>> sv/mfpr_pkg.sv
// shared types, constants and crc function for the marker framed packet receiver
package mfpr_pkg;

    // default number of marker byte slots
    localparam int MARKER_BYTES_DEF = 4;

    // crc-8 polynomial and ascii digit base
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] ASCII_ZERO = 8'd48;

    // configuration register indexes
    localparam logic [2:0] CFG_START_MARKER     = 3'd0;
    localparam logic [2:0] CFG_START_MARKER_LEN = 3'd1;
    localparam logic [2:0] CFG_STOP_MARKER      = 3'd2;
    localparam logic [2:0] CFG_STOP_MARKER_LEN  = 3'd3;
    localparam logic [2:0] CFG_CRC_CHECK_ENABLE = 3'd4;

    // configuration reset values
    localparam logic [31:0] START_MARKER_RST     = 32'd60;
    localparam logic [2:0]  START_MARKER_LEN_RST = 3'd1;
    localparam logic [31:0] STOP_MARKER_RST      = 32'd62;
    localparam logic [2:0]  STOP_MARKER_LEN_RST  = 3'd1;
    localparam logic        CRC_CHECK_ENABLE_RST = 1'b1;

    // result word kinds
    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_CRC_OK    = 3'd1,
        KIND_CRC_ERR   = 3'd2,
        KIND_ABORT     = 3'd3,
        KIND_UNCHECKED = 3'd4
    } kind_t;

    // configuration register set
    typedef struct packed {
        logic [31:0] start_marker;
        logic [2:0]  start_marker_len;
        logic [31:0] stop_marker;
        logic [2:0]  stop_marker_len;
        logic        crc_check_enable;
    } cfg_t;

    // one result word
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] index;
    } result_t;

    // crc-8, msb first, one byte folded in
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

>>> sv/mfpr_deframer.sv
// framing state and per-word decode logic of the packet receiver
module mfpr_deframer #(
    parameter int MARKER_BYTES = mfpr_pkg::MARKER_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            rx_data,
    input  mfpr_pkg::cfg_t        cfg,
    output logic                  res_valid,
    output mfpr_pkg::result_t     res
);

    localparam int CW = $clog2(MARKER_BYTES + 1);
    localparam int IW = (MARKER_BYTES > 1) ? $clog2(MARKER_BYTES) : 1;
    localparam int ND = 1 << IW;

    logic [CW-1:0] start_cnt_reg, start_cnt_next;
    logic          len_valid_reg, len_valid_next;
    logic [7:0]    decl_len_reg, decl_len_next;
    logic [7:0]    rx_crc_reg, rx_crc_next;
    logic [7:0]    pay_cnt_reg, pay_cnt_next;
    logic [7:0]    run_crc_reg, run_crc_next;
    logic [CW-1:0] stop_cnt_reg, stop_cnt_next;

    logic [7:0]    start_tab [ND];
    logic [7:0]    stop_tab [ND];
    logic [CW-1:0] start_len_eff;
    logic [CW-1:0] stop_len_eff;
    logic [CW-1:0] stop_cnt_inc;

    // marker byte tables, slots past the 32-bit register read as zero
    for (genvar g = 0; g < ND; g++) begin : g_tab
        if (g < 4) begin : g_real
            assign start_tab[g] = cfg.start_marker[8*g +: 8];
            assign stop_tab[g]  = cfg.stop_marker[8*g +: 8];
        end
        else begin : g_pad
            assign start_tab[g] = 8'h00;
            assign stop_tab[g]  = 8'h00;
        end
    end

    // effective marker lengths, clamped to 1..MARKER_BYTES
    always_comb
    begin
        if (cfg.start_marker_len == 3'd0)
            start_len_eff = CW'(1);
        else if (32'(cfg.start_marker_len) > 32'(MARKER_BYTES))
            start_len_eff = CW'(MARKER_BYTES);
        else
            start_len_eff = CW'(cfg.start_marker_len);

        if (cfg.stop_marker_len == 3'd0)
            stop_len_eff = CW'(1);
        else if (32'(cfg.stop_marker_len) > 32'(MARKER_BYTES))
            stop_len_eff = CW'(MARKER_BYTES);
        else
            stop_len_eff = CW'(cfg.stop_marker_len);
    end

    assign stop_cnt_inc = stop_cnt_reg + CW'(1);

    // decode of one received word
    always_comb
    begin
        start_cnt_next = start_cnt_reg;
        len_valid_next = len_valid_reg;
        decl_len_next  = decl_len_reg;
        rx_crc_next    = rx_crc_reg;
        pay_cnt_next   = pay_cnt_reg;
        run_crc_next   = run_crc_reg;
        stop_cnt_next  = stop_cnt_reg;
        res_valid      = 1'b0;
        res.kind       = mfpr_pkg::KIND_PAYLOAD;
        res.data       = 8'h00;
        res.index      = 8'h00;

        if (step) begin
            if (start_cnt_reg < start_len_eff) begin
                // start marker phase, a mismatch drops the frame
                if (start_tab[start_cnt_reg[IW-1:0]] == rx_data) begin
                    start_cnt_next = start_cnt_reg + CW'(1);
                end
                else begin
                    start_cnt_next = '0;
                    len_valid_next = 1'b0;
                    decl_len_next  = 8'h00;
                    rx_crc_next    = 8'h00;
                    pay_cnt_next   = 8'h00;
                    run_crc_next   = 8'h00;
                    stop_cnt_next  = '0;
                end
            end
            else if (!len_valid_reg) begin
                // ascii length digit, nothing at or below '0' is taken
                if (rx_data > mfpr_pkg::ASCII_ZERO) begin
                    decl_len_next  = rx_data - mfpr_pkg::ASCII_ZERO;
                    len_valid_next = 1'b1;
                end
            end
            else if (rx_crc_reg == 8'h00) begin
                // crc byte, zero keeps waiting
                rx_crc_next = rx_data;
            end
            else if (pay_cnt_reg < decl_len_reg) begin
                // payload pass-through
                res_valid    = 1'b1;
                res.kind     = mfpr_pkg::KIND_PAYLOAD;
                res.data     = rx_data;
                res.index    = pay_cnt_reg;
                run_crc_next = mfpr_pkg::crc8_step(run_crc_reg, rx_data);
                pay_cnt_next = pay_cnt_reg + 8'd1;
            end
            else if (stop_tab[stop_cnt_reg[IW-1:0]] == rx_data) begin
                // stop marker phase
                stop_cnt_next = stop_cnt_inc;
                if (stop_cnt_inc >= stop_len_eff) begin
                    res_valid = 1'b1;
                    if (!cfg.crc_check_enable)
                        res.kind = mfpr_pkg::KIND_UNCHECKED;
                    else if (run_crc_reg == rx_crc_reg)
                        res.kind = mfpr_pkg::KIND_CRC_OK;
                    else
                        res.kind = mfpr_pkg::KIND_CRC_ERR;
                    start_cnt_next = '0;
                    len_valid_next = 1'b0;
                    decl_len_next  = 8'h00;
                    rx_crc_next    = 8'h00;
                    pay_cnt_next   = 8'h00;
                    run_crc_next   = 8'h00;
                    stop_cnt_next  = '0;
                end
            end
            else begin
                // stop marker mismatch aborts the frame
                res_valid      = 1'b1;
                res.kind       = mfpr_pkg::KIND_ABORT;
                start_cnt_next = '0;
                len_valid_next = 1'b0;
                decl_len_next  = 8'h00;
                rx_crc_next    = 8'h00;
                pay_cnt_next   = 8'h00;
                run_crc_next   = 8'h00;
                stop_cnt_next  = '0;
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_cnt_reg <= '0;
            len_valid_reg <= 1'b0;
            decl_len_reg  <= 8'h00;
            rx_crc_reg    <= 8'h00;
            pay_cnt_reg   <= 8'h00;
            run_crc_reg   <= 8'h00;
            stop_cnt_reg  <= '0;
        end
        else begin
            start_cnt_reg <= start_cnt_next;
            len_valid_reg <= len_valid_next;
            decl_len_reg  <= decl_len_next;
            rx_crc_reg    <= rx_crc_next;
            pay_cnt_reg   <= pay_cnt_next;
            run_crc_reg   <= run_crc_next;
            stop_cnt_reg  <= stop_cnt_next;
        end
    end

endmodule

>>> sv/marker_framed_packet_receiver_crc8_top.sv
// top level of the marker framed packet receiver with crc-8 check
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  input    | in_valid, in_stall, rx_byte           | in
//  output   | out_valid, out_stall, kind,           | out
//           | payload_byte, payload_index           |
//  config   | cfg_we, cfg_index, cfg_data           | in
//
//  one word per cycle while the output does not stall; a taken word is held in the
//  input register, decoded from there, and its result is written to the output register.
//  reset clears the frame state and loads the register defaults.
//  a stalled output word holds the decode stage; the input stalls only when
//  its register is full and cannot move on.
module marker_framed_packet_receiver_crc8_top #(
    parameter int MARKER_BYTES = mfpr_pkg::MARKER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_index,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    mfpr_pkg::cfg_t    cfg_reg, cfg_next;
    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    mfpr_pkg::result_t out_res_reg;
    logic              advance;
    logic              in_take;
    logic              res_valid;
    mfpr_pkg::result_t res;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                mfpr_pkg::CFG_START_MARKER:     cfg_next.start_marker     = cfg_data;
                mfpr_pkg::CFG_START_MARKER_LEN: cfg_next.start_marker_len = cfg_data[2:0];
                mfpr_pkg::CFG_STOP_MARKER:      cfg_next.stop_marker      = cfg_data;
                mfpr_pkg::CFG_STOP_MARKER_LEN:  cfg_next.stop_marker_len  = cfg_data[2:0];
                mfpr_pkg::CFG_CRC_CHECK_ENABLE: cfg_next.crc_check_enable = cfg_data[0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker     <= mfpr_pkg::START_MARKER_RST;
            cfg_reg.start_marker_len <= mfpr_pkg::START_MARKER_LEN_RST;
            cfg_reg.stop_marker      <= mfpr_pkg::STOP_MARKER_RST;
            cfg_reg.stop_marker_len  <= mfpr_pkg::STOP_MARKER_LEN_RST;
            cfg_reg.crc_check_enable <= mfpr_pkg::CRC_CHECK_ENABLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // handshake: decode moves when the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = res_valid;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= rx_byte;
    end

    // frame decode
    mfpr_deframer #(
        .MARKER_BYTES(MARKER_BYTES)
    ) u_deframer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_data   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_res_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_res_reg.kind;
    assign payload_byte  = out_res_reg.data;
    assign payload_index = out_res_reg.index;

endmodule

>>> tb/deframe_checker.sv
// framing helpers and the result scoreboard for the packet receiver testbench
`timescale 1ns / 1ps

package deframe_tb_pkg;

    // crc-8 over one byte, shifted in a bit at a time, msb first
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ d[i];
            c  = {c[6:0], 1'b0} ^ (fb ? mfpr_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // marker bytes in use for a length register value
    function automatic int unsigned marker_span(input logic [2:0] len);
        if (len == 3'd0)
            return 1;
        if (len > mfpr_pkg::MARKER_BYTES_DEF)
            return mfpr_pkg::MARKER_BYTES_DEF;
        return len;
    endfunction

    // one marker byte, zero past the register
    function automatic logic [7:0] marker_at(input logic [31:0] pat, input int unsigned k);
        if (k >= 4)
            return 8'h00;
        return pat[8*k +: 8];
    endfunction

endpackage

module deframe_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  payload_byte,
    input  logic [7:0]  payload_index,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          words_waiting
);
    import mfpr_pkg::*;
    import deframe_tb_pkg::*;

    // register copies
    logic [31:0] start_pat;
    logic [2:0]  start_len;
    logic [31:0] stop_pat;
    logic [2:0]  stop_len;
    logic        crc_on;

    // frame tracking
    logic [2:0]  start_seen;
    logic        len_taken;
    logic [7:0]  frame_len;
    logic [7:0]  frame_crc;
    logic [7:0]  body_cnt;
    logic [7:0]  body_crc;
    logic [2:0]  stop_seen;

    result_t     expected_words[$];

    task automatic clear_frame();
        start_seen = '0;
        len_taken  = 1'b0;
        frame_len  = '0;
        frame_crc  = '0;
        body_cnt   = '0;
        body_crc   = '0;
        stop_seen  = '0;
    endtask

    // advance the frame tracker by one received byte, queue what it yields
    task automatic deframe_byte(input logic [7:0] b);
        result_t w;
        kind_t   verdict;
        w = '0;
        if (start_seen < marker_span(start_len))
        begin
            // start marker, a mismatch drops the byte
            if (marker_at(start_pat, start_seen) == b)
                start_seen = start_seen + 3'd1;
            else
                clear_frame();
        end
        else if (!len_taken)
        begin
            // ascii length digit, zero or below keeps waiting
            if (b > ASCII_ZERO)
            begin
                frame_len = b - ASCII_ZERO;
                len_taken = 1'b1;
            end
        end
        else if (frame_crc == 8'h00)
        begin
            frame_crc = b;
        end
        else if (body_cnt < frame_len)
        begin
            w.kind  = KIND_PAYLOAD;
            w.data  = b;
            w.index = body_cnt;
            expected_words.push_back(w);
            body_crc = crc8_fold(body_crc, b);
            body_cnt = body_cnt + 8'd1;
        end
        else if (marker_at(stop_pat, stop_seen) == b)
        begin
            stop_seen = stop_seen + 3'd1;
            if (stop_seen >= marker_span(stop_len))
            begin
                if (!crc_on)
                    verdict = KIND_UNCHECKED;
                else if (body_crc == frame_crc)
                    verdict = KIND_CRC_OK;
                else
                    verdict = KIND_CRC_ERR;
                w.kind = verdict;
                expected_words.push_back(w);
                clear_frame();
            end
        end
        else
        begin
            // broken stop marker aborts the packet
            clear_frame();
            w.kind = KIND_ABORT;
            expected_words.push_back(w);
        end
    endtask

    // compare one result word against the oldest expectation
    task automatic check_word();
        result_t w;
        if (expected_words.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected word: kind %0d byte %02h index %0d",
                         kind, payload_byte, payload_index);
            mismatches++;
        end
        else
        begin
            w = expected_words.pop_front();
            if (kind !== w.kind || payload_byte !== w.data || payload_index !== w.index)
            begin
                if (mismatches < 10)
                    $display("mismatch: expected kind %0d byte %02h index %0d, got kind %0d byte %02h index %0d",
                             w.kind, w.data, w.index, kind, payload_byte, payload_index);
                mismatches++;
            end
        end
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pat  = START_MARKER_RST;
            start_len  = START_MARKER_LEN_RST;
            stop_pat   = STOP_MARKER_RST;
            stop_len   = STOP_MARKER_LEN_RST;
            crc_on     = CRC_CHECK_ENABLE_RST;
            clear_frame();
            expected_words.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_word();
            if (in_valid && !in_stall)
                deframe_byte(rx_byte);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_MARKER:     start_pat = cfg_data;
                    CFG_START_MARKER_LEN: start_len = cfg_data[2:0];
                    CFG_STOP_MARKER:      stop_pat  = cfg_data;
                    CFG_STOP_MARKER_LEN:  stop_len  = cfg_data[2:0];
                    CFG_CRC_CHECK_ENABLE: crc_on    = cfg_data[0];
                    default: ;
                endcase
            end
        end
        words_waiting = expected_words.size();
    end

endmodule

>>> tb/testbench.sv
// stimulus and verdict for the marker framed packet receiver
`timescale 1ns / 1ps

module testbench;
    import mfpr_pkg::*;
    import deframe_tb_pkg::*;

    localparam int         CYCLE_LIMIT = 300000;
    localparam logic [2:0] CFG_NO_REG  = 3'd7;   // unmapped index, write is ignored

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    int          fail_count;
    int          words_pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_left;
    int          cycle_count = 0;
    int          words_sent  = 0;

    // framing currently programmed, used to build packets
    logic [31:0] cur_start;
    logic [2:0]  cur_start_len;
    logic [31:0] cur_stop;
    logic [2:0]  cur_stop_len;

    marker_framed_packet_receiver_crc8_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    deframe_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (fail_count),
        .words_waiting (words_pending)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stalls at random, or holds off for a counted stretch
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // offer one word, return at the falling edge after it is taken
    task automatic send_word(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_START_MARKER:     cur_start     = value;
            CFG_START_MARKER_LEN: cur_start_len = value[2:0];
            CFG_STOP_MARKER:      cur_stop      = value;
            CFG_STOP_MARKER_LEN:  cur_stop_len  = value[2:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // let every expected word arrive and the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // one packet with random payload; stop marker sent up to stop_upto,
    // optionally followed by a wrong stop byte
    task automatic send_frame(input int n, input bit good_crc, input bit from_length,
                              input int stop_upto, input bit stop_bad);
        logic [7:0] body[$];
        logic [7:0] c;
        c = 8'h00;
        if (!from_length)
            for (int k = 0; k < marker_span(cur_start_len); k++)
                send_word(marker_at(cur_start, k));
        // a length byte too small to count now and then
        if ($urandom_range(7) == 0)
            send_word(8'($urandom_range(48)));
        send_word(8'(48 + n));
        for (int k = 0; k < n; k++)
        begin
            body.push_back(8'($urandom_range(255)));
            c = crc8_fold(c, body[k]);
        end
        if (!good_crc)
            c = c ^ 8'($urandom_range(255, 1));
        if (c == 8'h00)
            c = 8'h01;
        // zero crc bytes are skipped by the block
        if ($urandom_range(7) == 0)
            send_word(8'h00);
        send_word(c);
        foreach (body[k])
            send_word(body[k]);
        for (int k = 0; k < stop_upto; k++)
            send_word(marker_at(cur_stop, k));
        if (stop_bad)
            send_word(marker_at(cur_stop, stop_upto) ^ 8'($urandom_range(255, 1)));
    endtask

    // mostly whole packets, some aborts, broken starts and line noise
    task automatic random_traffic(input int budget);
        int first;
        int n;
        int pick;
        int k;
        first = words_sent;
        while (words_sent - first < budget)
        begin
            pick = $urandom_range(99);
            n = ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(9, 1);
            if (pick < 70)
                send_frame(n, $urandom_range(9) < 6, 1'b0, marker_span(cur_stop_len), 1'b0);
            else if (pick < 82)
                send_frame(n, 1'b1, 1'b0, $urandom_range(marker_span(cur_stop_len) - 1), 1'b1);
            else if (pick < 92)
            begin
                k = $urandom_range(marker_span(cur_start_len) - 1);
                for (int i = 0; i < k; i++)
                    send_word(marker_at(cur_start, i));
                send_word(marker_at(cur_start, k) ^ 8'($urandom_range(255, 1)));
            end
            else
            begin
                // noise never matches the first start byte, so framing stays aligned
                repeat ($urandom_range(4, 1))
                    send_word(marker_at(cur_start, 0) ^ 8'($urandom_range(255, 1)));
            end
        end
    endtask

    initial
    begin
        logic [7:0] c;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        cfg_we        = 1'b0;
        cfg_index     = CFG_START_MARKER;
        cfg_data      = 32'h0;
        send_idle_pct = 31;
        recv_idle_pct = 80;
        cur_start     = START_MARKER_RST;
        cur_start_len = START_MARKER_LEN_RST;
        cur_stop      = STOP_MARKER_RST;
        cur_stop_len  = STOP_MARKER_LEN_RST;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default framing: minimal packet, then short length and zero crc bytes
        send_frame(1, 1'b1, 1'b0, 1, 1'b0);
        c = crc8_fold(crc8_fold(8'h00, 8'h00), 8'hFF);
        send_word(marker_at(cur_start, 0));
        send_word(8'h00);
        send_word(ASCII_ZERO);
        send_word(8'(ASCII_ZERO + 2));
        send_word(8'h00);
        send_word(c);
        send_word(8'h00);
        send_word(8'hFF);
        send_word(marker_at(cur_stop, 0));
        // crc error, start mismatch, stop mismatch
        send_frame(3, 1'b0, 1'b0, 1, 1'b0);
        send_word(8'hFF);
        send_frame(2, 1'b1, 1'b0, 0, 1'b1);
        drain();

        // widest markers, checking off, unmapped register
        write_reg(CFG_START_MARKER, 32'hFFFF_FFFF);
        write_reg(CFG_START_MARKER_LEN, 32'd4);
        write_reg(CFG_STOP_MARKER, 32'h0000_0000);
        write_reg(CFG_STOP_MARKER_LEN, 32'd4);
        write_reg(CFG_CRC_CHECK_ENABLE, 32'd0);
        write_reg(CFG_NO_REG, $urandom);
        send_frame(2, 1'b1, 1'b0, 4, 1'b0);
        drain();

        // first random phase, sender gaps and heavy receiver stalls
        write_reg(CFG_CRC_CHECK_ENABLE, 32'd1);
        write_reg(CFG_START_MARKER, $urandom);
        write_reg(CFG_STOP_MARKER, $urandom);
        random_traffic(130);
        // leave two start bytes matched, then shorten the start marker
        send_word(marker_at(cur_start, 0));
        send_word(marker_at(cur_start, 1));
        drain();

        // second phase, roles swapped
        send_idle_pct = 80;
        recv_idle_pct <= 31;
        write_reg(CFG_START_MARKER_LEN, 32'd0);
        send_frame(3, 1'b1, 1'b1, 4, 1'b0);
        drain();
        write_reg(CFG_STOP_MARKER_LEN, 32'd7);
        write_reg(CFG_CRC_CHECK_ENABLE, 32'd0);
        random_traffic(130);
        // three stop bytes matched, then shorten the stop marker
        send_frame(2, 1'b1, 1'b0, 3, 1'b0);
        drain();
        write_reg(CFG_STOP_MARKER_LEN, 32'd2);
        send_word(marker_at(cur_stop, 3));
        drain();

        // third phase, no idling, then a long receiver hold
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        write_reg(CFG_START_MARKER, $urandom);
        write_reg(CFG_START_MARKER_LEN, 32'($urandom_range(4, 1)));
        write_reg(CFG_STOP_MARKER, $urandom);
        write_reg(CFG_STOP_MARKER_LEN, 32'($urandom_range(4, 1)));
        write_reg(CFG_CRC_CHECK_ENABLE, 32'd1);
        random_traffic(50);
        hold_left <= 300;
        send_frame(207, 1'b1, 1'b0, marker_span(cur_stop_len), 1'b0);
        random_traffic(50);
        drain();
        repeat (10) @(negedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
sv/mfpr_pkg.sv
sv/mfpr_deframer.sv
sv/marker_framed_packet_receiver_crc8_top.sv
tb/deframe_checker.sv
tb/testbench.sv
